@@ src/ptw_pkg.sv @@
// ----------------------------------------------------------------------------
// ptw_pkg
// shared constants, codes and helpers of the four-level page table walker
// ----------------------------------------------------------------------------
package ptw_pkg;

	localparam int MEM_WORDS      = 32768;
	localparam int WORDS_PER_PAGE = 1024;
	localparam int AW             = $clog2(MEM_WORDS);
	localparam int PAGES          = MEM_WORDS / WORDS_PER_PAGE;
	// largest page count that the 6-bit memory_pages register can express
	localparam int PP_CAP         = (PAGES > 63) ? 63 : PAGES;

	localparam int VA_W   = 53;
	localparam int IDX_W  = 10;
	localparam int OFS_W  = 13;
	localparam int PA_W   = 18;
	localparam int WORD_W = 64;
	localparam int WIDX_W = 15;
	localparam int PG_W   = 6;

	// virtual address index fields per level
	localparam int LVL0_LSB = 43;
	localparam int LVL1_LSB = 33;
	localparam int LVL2_LSB = 23;
	localparam int LVL3_LSB = 13;

	// entry bits
	localparam int BIT_PRESENT  = 0;
	localparam int BIT_READ     = 1;
	localparam int BIT_WRITE    = 2;
	localparam int BIT_EXEC     = 3;
	localparam int BIT_USER     = 4;
	localparam int BIT_ACCESSED = 5;
	localparam int BIT_DIRTY    = 6;
	localparam int FRAME_LSB    = 8;

	// item kinds
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_XLATE = 2'd2;

	// access codes
	localparam logic [1:0] ACC_READ  = 2'd0;
	localparam logic [1:0] ACC_WRITE = 2'd1;
	localparam logic [1:0] ACC_EXEC  = 2'd2;

	// register indexes
	localparam logic CFG_ROOT  = 1'b0;
	localparam logic CFG_PAGES = 1'b1;

	localparam logic [1:0] LVL_LEAF = 2'd3;

	function automatic logic [IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
		input logic [1:0] lvl);
		logic [IDX_W-1:0] idx;
		case (lvl)
			2'd0:    idx = va[LVL0_LSB +: IDX_W];
			2'd1:    idx = va[LVL1_LSB +: IDX_W];
			2'd2:    idx = va[LVL2_LSB +: IDX_W];
			default: idx = va[LVL3_LSB +: IDX_W];
		endcase
		return idx;
	endfunction

endpackage

@@ src/ptw_ram.sv @@
// ----------------------------------------------------------------------------
// ptw_ram
// generic single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module ptw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

@@ src/four_level_page_table_walker_core.sv @@
// ----------------------------------------------------------------------------
// four_level_page_table_walker_core
// four-level page table walker over a word-addressed physical memory
// ----------------------------------------------------------------------------
// usage
//  - input channel (in_valid/in_ready) carries one item per transfer: a word
//    write (kind 0), a word read (kind 1) or a translate (kind 2)
//  - output channel (out_valid/out_ready) returns one result per item:
//    fault, phys_addr and read_data
//  - configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
//    issue them only while the block is idle
//  - a translate does one table read per level through the single memory
//    port; the leaf check and the write-back of the accessed/dirty bits
//    share the state in which the leaf entry is on the ram output
//  - a word read passes through S_RDW and S_FIN; a word write or an unused kind goes straight to S_FIN
//  - items are handled one at a time; a new item is taken as soon as the
//    previous one has moved into the output register, so a stalled receiver
//    holds only one finished result while the next item is worked on
//  - after reset the memory is swept to zero, one word per cycle, over all
//    MEM_WORDS (32768) words; in_ready stays low during the sweep
//  - a walk that faults has no effect on memory
// ----------------------------------------------------------------------------
module four_level_page_table_walker_core
	import ptw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [PA_W-1:0]   cfg_data,
	// input items
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        kind,
	input  logic [VA_W-1:0]   virt_addr,
	input  logic [1:0]        access,
	input  logic              user_mode,
	input  logic [WIDX_W-1:0] word_index,
	input  logic [WORD_W-1:0] word_data,
	// results
	output logic              out_valid,
	input  logic              out_ready,
	output logic              fault,
	output logic [PA_W-1:0]   phys_addr,
	output logic [WORD_W-1:0] read_data
);

	typedef enum logic [2:0] {
		S_CLEAR,  // zero sweep after reset
		S_IDLE,   // waiting for an input transfer
		S_CHECK,  // table entry of level lvl_q is on the ram output
		S_RDW,    // word read data is on the ram output
		S_FIN     // result ready, waiting for the output register
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     clr_q;
	logic [1:0]        lvl_q;
	logic [AW-1:0]     addr_q;      // ram address of the entry being checked
	logic [VA_W-1:0]   va_q;
	logic [1:0]        access_q;
	logic              user_q;
	logic              inrange_q;

	// result waiting for the output register
	logic              res_fault_q;
	logic [PA_W-1:0]   res_pa_q;
	logic [WORD_W-1:0] res_data_q;

	// output register
	logic              out_valid_q;
	logic              fault_q;
	logic [PA_W-1:0]   pa_q;
	logic [WORD_W-1:0] data_q;

	// configuration registers
	logic [PA_W-1:0]   root_q;
	logic [PG_W-1:0]   mem_pages_q;

	// ram port
	logic              ram_en;
	logic              ram_we;
	logic [AW-1:0]     ram_addr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;

	ptw_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MEM_WORDS)
	) u_mem (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// walk checks
	// ------------------------------------------------------------------
	logic [PG_W-1:0]         pages_present;
	logic [PG_W-2:0]         root_page;
	logic                    root_ok;
	logic                    in_accept;
	logic                    word_inrange;
	logic [WORD_W-1:0]       entry;
	logic [WORD_W-FRAME_LSB-1:0] frame;
	logic                    frame_ok;
	logic                    perm_ok;
	logic                    leaf;
	logic                    walk_ok;
	logic [WORD_W-1:0]       need;
	logic [AW-1:0]           next_addr;
	logic                    slot_free;

	// pages that exist: the smaller of the register and the memory size
	assign pages_present = (mem_pages_q < PG_W'(PP_CAP)) ? mem_pages_q : PG_W'(PP_CAP);

	assign root_page    = root_q[PA_W-1:OFS_W];
	assign root_ok      = {1'b0, root_page} < pages_present;
	assign in_accept    = in_valid && in_ready;
	assign word_inrange = 32'(word_index) < 32'(MEM_WORDS);

	assign entry    = ram_rdata;
	assign frame    = entry[WORD_W-1:FRAME_LSB];
	// frame numbers are compared in full: any high bit set means no page
	assign frame_ok = (frame[WORD_W-FRAME_LSB-1:PG_W] == '0) &&
		(frame[PG_W-1:0] < pages_present);
	assign leaf     = (lvl_q == LVL_LEAF);

	always_comb begin
		need    = '0;
		perm_ok = 1'b1;
		case (access_q)
			ACC_READ:  need[BIT_READ]  = 1'b1;
			ACC_WRITE: need[BIT_WRITE] = 1'b1;
			ACC_EXEC:  need[BIT_EXEC]  = 1'b1;
			default:   perm_ok = 1'b0;  // unknown access grants nothing
		endcase
		if (user_q) begin
			need[BIT_USER] = 1'b1;
		end
		if ((entry & need) != need) begin
			perm_ok = 1'b0;
		end
	end

	assign walk_ok   = entry[BIT_PRESENT] && frame_ok && (!leaf || perm_ok);
	assign next_addr = AW'({frame[PG_W-1:0], va_index(va_q, lvl_q + 2'd1)});

	// output register can take a new result this cycle
	assign slot_free = !out_valid_q || out_ready;

	assign in_ready = (state_q == S_IDLE);

	// ------------------------------------------------------------------
	// ram port control
	// ------------------------------------------------------------------
	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = addr_q;
		ram_wdata = word_data;
		case (state_q)
			S_CLEAR: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
			end
			S_IDLE: begin
				if (in_accept) begin
					case (kind)
						KIND_WRITE: begin
							ram_en   = word_inrange;
							ram_we   = 1'b1;
							ram_addr = AW'(word_index);
						end
						KIND_READ: begin
							ram_en   = 1'b1;
							ram_addr = AW'(word_index);
						end
						KIND_XLATE: begin
							// top-level entry read issued with the transfer
							ram_en   = 1'b1;
							ram_addr = AW'({root_page, va_index(virt_addr, 2'd0)});
						end
						default: ;
					endcase
				end
			end
			S_CHECK: begin
				if (!leaf) begin
					ram_en   = 1'b1;
					ram_addr = next_addr;
				end else if (walk_ok) begin
					// leaf write-back of accessed and dirty bits
					ram_en    = 1'b1;
					ram_we    = 1'b1;
					ram_addr  = addr_q;
					ram_wdata = entry;
					ram_wdata[BIT_ACCESSED] = 1'b1;
					if (access_q == ACC_WRITE) begin
						ram_wdata[BIT_DIRTY] = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// state, configuration and result registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			lvl_q       <= '0;
			addr_q      <= '0;
			va_q        <= '0;
			access_q    <= '0;
			user_q      <= 1'b0;
			inrange_q   <= 1'b0;
			res_fault_q <= 1'b0;
			res_pa_q    <= '0;
			res_data_q  <= '0;
			out_valid_q <= 1'b0;
			fault_q     <= 1'b0;
			pa_q        <= '0;
			data_q      <= '0;
			root_q      <= '0;
			mem_pages_q <= PG_W'(32);
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ROOT:  root_q      <= cfg_data;
					CFG_PAGES: mem_pages_q <= cfg_data[PG_W-1:0];
					default: ;
				endcase
			end

			// a finished result in S_FIN refills the register instead
			if (out_valid_q && out_ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MEM_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_accept) begin
						va_q        <= virt_addr;
						access_q    <= access;
						user_q      <= user_mode;
						inrange_q   <= word_inrange;
						lvl_q       <= '0;
						addr_q      <= AW'({root_page, va_index(virt_addr, 2'd0)});
						res_fault_q <= 1'b0;
						res_pa_q    <= '0;
						res_data_q  <= '0;
						case (kind)
							KIND_READ: state_q <= S_RDW;
							KIND_XLATE: begin
								if (root_ok) begin
									state_q <= S_CHECK;
								end else begin
									res_fault_q <= 1'b1;
									state_q     <= S_FIN;
								end
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_CHECK: begin
					if (!walk_ok) begin
						res_fault_q <= 1'b1;
						state_q     <= S_FIN;
					end else if (leaf) begin
						res_pa_q <= {frame[PA_W-OFS_W-1:0], va_q[OFS_W-1:0]};
						state_q  <= S_FIN;
					end else begin
						lvl_q  <= lvl_q + 2'd1;
						addr_q <= next_addr;
					end
				end
				S_RDW: begin
					res_data_q <= inrange_q ? ram_rdata : '0;
					state_q    <= S_FIN;
				end
				S_FIN: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						fault_q     <= res_fault_q;
						pa_q        <= res_pa_q;
						data_q      <= res_data_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign fault     = fault_q;
	assign phys_addr = pa_q;
	assign read_data = data_q;

endmodule
